// ===== rtl/i2d_pkg.sv =====
// Shared constants, types and helpers for the integer to decimal text core.
package i2d_pkg;

  localparam int DEF_VALUE_BITS = 32;

  localparam logic [7:0] SEP_CHAR   = 8'h20;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  // Decimal digits needed for any magnitude of the given bit count
  // (1233/4096 is just below log10(2), exact enough up to 64 bits).
  function automatic int num_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  // Per-cycle command to every digit cell.
  typedef struct packed {
    logic clear;    // zero the digit
    logic convert;  // add-3 correction, then shift in a bit from below
    logic shift;    // take the digit of the cell below
  } cell_ctrl_t;

endpackage

// ===== rtl/i2d_cell.sv =====
// One BCD digit cell of the double-dabble chain.
module i2d_cell import i2d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       bit_i,
  input  logic [3:0] digit_i,
  output logic       carry_o,
  output logic [3:0] digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] corr;

  always_comb begin
    corr    = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
    carry_o = corr[3];
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.convert) begin
      digit_d = {corr[2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

// ===== rtl/int_to_decimal_ascii_core.sv =====
// Top level: signed integer to a run of decimal ASCII characters.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------
//   input   | in_valid_i  | in_stall_o  | value_i
//   output  | out_valid_o | out_stall_i | out_char_o, last_o
//
// Sequence: a word is accepted in idle, runs the bit-serial double-dabble
// pass through the digit-cell chain, then emits the separator, a minus sign
// when negative, and the digits shifted out of the top cell with leading
// zeros dropped; output stalls hold the run.
// Reset (async, active low) returns the sequencer to idle and empties the
// output register. The input is stalled for the whole run of a word.
module int_to_decimal_ascii_core import i2d_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_char_o,
  output logic                         last_o
);

  localparam int NDIG  = num_digits(VALUE_BITS);
  localparam int BCW   = $clog2(VALUE_BITS + 1);
  localparam int DCW   = $clog2(NDIG + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SEP   = 3'd2;
  localparam logic [2:0] ST_MINUS = 3'd3;
  localparam logic [2:0] ST_SKIP  = 3'd4;
  localparam logic [2:0] ST_DIGIT = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [BCW-1:0]        bcnt_q, bcnt_d;
  logic [DCW-1:0]        dcnt_q, dcnt_d;

  logic                  ovalid_q, ovalid_d;
  logic [7:0]            ochar_q, ochar_d;
  logic                  olast_q, olast_d;

  cell_ctrl_t            ctrl;
  logic [3:0]            digit [NDIG];
  logic                  carry [NDIG];
  logic [3:0]            top_digit;

  logic                  in_acc;
  logic                  can_load;
  logic [VALUE_BITS-1:0] value_u;
  logic                  neg_in;

  assign value_u   = $unsigned(value_i);
  assign neg_in    = value_u[VALUE_BITS-1];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  // Output register is free or being emptied this cycle.
  assign can_load  = !ovalid_q || !out_stall_i;
  assign top_digit = digit[NDIG-1];

  // Digit chain: bits enter at cell 0 during conversion, digits move up
  // toward the top cell during output.
  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    logic       bit_in;
    logic [3:0] dig_in;
    if (k == 0) begin : g_first
      assign bit_in = mag_q[VALUE_BITS-1];
      assign dig_in = 4'd0;
    end else begin : g_rest
      assign bit_in = carry[k-1];
      assign dig_in = digit[k-1];
    end
    i2d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (bit_in),
      .digit_i (dig_in),
      .carry_o (carry[k]),
      .digit_o (digit[k])
    );
  end

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    bcnt_d   = bcnt_q;
    dcnt_d   = dcnt_q;
    ctrl     = '0;
    ovalid_d = ovalid_q && out_stall_i;
    ochar_d  = ochar_q;
    olast_d  = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d      = neg_in;
          mag_d      = (value_u ^ {VALUE_BITS{neg_in}}) + VALUE_BITS'(neg_in);
          bcnt_d     = BCW'(VALUE_BITS);
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.convert = 1'b1;
        mag_d        = mag_q << 1;
        bcnt_d       = bcnt_q - BCW'(1);
        if (bcnt_q == BCW'(1)) begin
          dcnt_d  = DCW'(NDIG);
          state_d = ST_SEP;
        end
      end
      ST_SEP: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          ochar_d  = SEP_CHAR;
          olast_d  = 1'b0;
          state_d  = neg_q ? ST_MINUS : ST_SKIP;
        end
      end
      ST_MINUS: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          ochar_d  = MINUS_CHAR;
          olast_d  = 1'b0;
          state_d  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros; the final digit always prints.
        if ((top_digit == 4'd0) && (dcnt_q != DCW'(1))) begin
          ctrl.shift = 1'b1;
          dcnt_d     = dcnt_q - DCW'(1);
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (can_load) begin
          ovalid_d   = 1'b1;
          ochar_d    = DIGIT_BASE + {4'd0, top_digit};
          olast_d    = (dcnt_q == DCW'(1));
          ctrl.shift = 1'b1;
          dcnt_d     = dcnt_q - DCW'(1);
          if (dcnt_q == DCW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      bcnt_q   <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      bcnt_q   <= bcnt_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign last_o      = olast_q;

endmodule

// ===== rtl/i2d_checker.sv =====
// Port-level checks for the integer to decimal text core, with its bind.
module i2d_checker import i2d_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic signed [VALUE_BITS-1:0] value_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [7:0]                   out_char_o,
  input logic                         last_o
);

  // A stalled input word holds until taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(value_i)))
    else $error("stalled input word changed");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_char_o) && $stable(last_o)))
    else $error("stalled output word changed");

  // One word at a time: an accepted input blocks the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // The marked word is always a digit.
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (out_char_o >= 8'h30 && out_char_o <= 8'h39))
    else $error("last marks a non-digit");

  // Separator and sign never end a run.
  a_sep_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_char_o == SEP_CHAR || out_char_o == MINUS_CHAR)) |-> !last_o)
    else $error("separator or sign marked last");

endmodule

bind int_to_decimal_ascii_core i2d_checker #(.VALUE_BITS(VALUE_BITS)) u_i2d_checker (.*);

// ===== dv/i2d_text_checker.sv =====
// Checker for the integer to decimal text core: predicts each character run and scores the output.
module i2d_text_checker import i2d_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            out_char_i,
  input  logic                  last_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    words_o,
  output int                    chars_o,
  output int                    negatives_o
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatch_cnt = 0;
  int         word_cnt     = 0;
  int         char_cnt     = 0;
  int         neg_cnt      = 0;

  // Space, optional minus, then magnitude digits MSD first; last flag on the final digit.
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] raw);
    logic                  neg;
    logic [VALUE_BITS-1:0] mag_w;
    longint unsigned       mag;
    logic [3:0]            digs[20];
    int                    nd;
    int                    i;
    neg   = raw[VALUE_BITS-1];
    // unsigned magnitude, so the most negative value prints exactly
    mag_w = neg ? (~raw + 1'b1) : raw;
    mag   = mag_w;
    nd    = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      mag      = mag / 10;
      nd++;
    end while (mag != 0);
    expected_text.push_back('{SEP_CHAR, 1'b0});
    if (neg) expected_text.push_back('{MINUS_CHAR, 1'b0});
    for (i = nd - 1; i >= 0; i--)
      expected_text.push_back('{DIGIT_BASE + 8'(digs[i]), (i == 0)});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : score
    text_char_t want;
    if (!rst_ni) begin
      expected_text.delete();
    end else begin
      // output side first: a word accepted on this edge cannot explain this char
      if (out_valid_i && !out_stall_i) begin
        char_cnt++;
        if (expected_text.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected char %h last %b with nothing pending", out_char_i, last_i);
          mismatch_cnt++;
        end else begin
          want = expected_text.pop_front();
          if (out_char_i !== want.code || last_i !== want.last) begin
            if (mismatch_cnt < 10)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.code, want.last, out_char_i, last_i);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        word_cnt++;
        if (value_i[VALUE_BITS-1]) neg_cnt++;
        queue_decimal_text(value_i);
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= expected_text.size();
    words_o      <= word_cnt;
    chars_o      <= char_cnt;
    negatives_o  <= neg_cnt;
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, word stimulus and output stalls for the decimal text core.
module testbench;
  import i2d_pkg::*;

  localparam int VALUE_BITS = DEF_VALUE_BITS;
  localparam int RAND_WORDS = 370;

  // Receiver back-pressure modes; each one holds for a random stretch.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] value     = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   out_char;
  logic                         last;

  int mismatches;
  int pending;
  int words;
  int chars;
  int negatives;

  always #6 clk = ~clk;

  int_to_decimal_ascii_core #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_char_o  (out_char),
    .last_o      (last)
  );

  i2d_text_checker #(.VALUE_BITS(VALUE_BITS)) text_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_char_i   (out_char),
    .last_i       (last),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_o      (words),
    .chars_o      (chars),
    .negatives_o  (negatives)
  );

  // --------------------------------------------------------------------------
  // Receiver stall pattern. Mode changes after a random stretch; stall runs are
  // capped so the worst-case drain time stays bounded. The NONE mode gives
  // long stretches of full-rate output.
  // --------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_run  = 0;
  int          cyc        = 0;

  always @(posedge clk) begin : stall_gen
    logic s;
    cyc <= cyc + 1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(30, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  s = 1'b0;
      STALL_LIGHT: s = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: s = ($urandom_range(0, 9) < 7);
      default:     s = ((cyc % 5) < 2);
    endcase
    if (stall_run >= 8) s = 1'b0;
    stall_run <= s ? stall_run + 1 : 0;
    out_stall <= s && rst_n;
  end

  // --------------------------------------------------------------------------
  // Sender. A word is offered after an optional gap and held until the core
  // drops its stall; in_stall only moves at rising edges, so it is sampled on
  // the falling edge before the edge that takes the word. A word that follows
  // without a gap keeps valid high with a single assignment per step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic signed [VALUE_BITS-1:0] v, input int gap);
    logic taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  // Random value: raw bit patterns, a uniform spread over digit counts
  // (so short and full-length runs both show up), and values next to a
  // power of ten where the digit count changes.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int              kind;
    int              n;
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0]     v;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      v = $urandom();
    end else if (kind < 8) begin
      n  = $urandom_range(1, 10);
      lo = (n == 1) ? 0 : pow10(n - 1);
      hi = pow10(n) - 1;
      if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
      v  = $urandom_range(32'(hi), 32'(lo));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      n = $urandom_range(0, 9);
      v = 32'(pow10(n)) + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return VALUE_BITS'(signed'(v));
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed corners, random bursts, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic signed [31:0] corner[$] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      32'sh7FFF_FFFF,          // largest positive, ten digits
      32'sh8000_0000,          // most negative, magnitude only fits unsigned
      -32'sd2147483647,
      32'sd999999999, 32'sd1000000000, 32'sd1000000001, -32'sd999999999,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sd12345, -32'sd7, -32'sd9
    };
    int sent;
    int burst;
    int gap;
    int k;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: back to back, with a few gaps mixed in.
    for (k = 0; k < corner.size(); k++)
      send_word(VALUE_BITS'(corner[k]), (k % 4 == 3) ? $urandom_range(1, 40) : 0);

    // Random bursts with random gaps, so a new word lands on every point of a word's run.
    sent = 0;
    while (sent < RAND_WORDS) begin
      burst = $urandom_range(1, 12);
      gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) burst = 40;   // long run with no sender idling
      for (k = 0; k < burst && sent < RAND_WORDS; k++) begin
        send_word(pick_value(), (k == 0) ? gap : 0);
        sent++;
      end
    end
    in_valid <= 1'b0;
    // let the pending count take in the last word
    @(posedge clk);

    // Drain, then give the core a word's worth of cycles to show stray output.
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d words (%0d negative) and %0d characters under bursts, gaps and stalls",
             words, negatives, chars);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatching characters", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Worst case per word is the conversion run, every character stalled as long as
  // allowed and the longest gap; the watchdog allows well over that for all words.
  initial begin : watchdog
    #4_800_000;
    $display("Timeout with %0d characters still pending", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
